// File: hdl/uqss_pkg.sv
package uqss_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int IDX_W = 5;
   localparam int TOTAL_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int NUM_SLOTS = 5;
   localparam int SLOT_W = 3;
   localparam int MAX_ENTRIES_DEF = 32;

   localparam logic [KIND_W-1:0] KIND_KEY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ENTRY_END = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY_END = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_LIMIT = 2'd2;

   localparam logic [7:0] KEY_LIMIT_RST = 8'd31;
   localparam logic [7:0] VALUE_LIMIT_RST = 8'd63;
   localparam logic [5:0] ENTRY_LIMIT_RST = 6'd32;

   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_AMP = 8'h26;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [NUM_SLOTS-1:0][KIND_W-1:0] kinds;
      logic [NUM_SLOTS-1:0][CHAR_W-1:0] chars;
      logic [IDX_W-1:0] index;
      logic [TOTAL_W-1:0] total;
   } bundle_type;

   function automatic logic is_hex(input logic [CHAR_W-1:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
      end
      hex_val = d[3:0];
   endfunction

   function automatic logic [CHAR_W-1:0] lit(input logic [CHAR_W-1:0] c);
      lit = (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

   function automatic logic [CHAR_W-1:0] fix_byte(input logic [CHAR_W-1:0] b,
                                                  input logic key);
      fix_byte = (key && b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
   endfunction

endpackage

// File: hdl/uqss_parse.sv
module uqss_parse #(
   parameter int MAX_ENTRIES = uqss_pkg::MAX_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [uqss_pkg::CHAR_W-1:0] req_char_in,
   input  logic req_has_char,
   input  logic req_query_end,
   input  logic csr_write,
   input  logic [uqss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [uqss_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic out_free,
   output logic load,
   output logic [uqss_pkg::SLOT_W-1:0] bundle_count,
   output uqss_pkg::bundle_type bundle
);

   localparam logic [1:0] PH_BETWEEN = 2'd0;
   localparam logic [1:0] PH_KEY = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;
   localparam int ED_W = uqss_pkg::TOTAL_W;
   localparam int CMP_W = ($clog2(MAX_ENTRIES + 1) > ED_W) ? $clog2(MAX_ENTRIES + 1) : ED_W;

   logic in_valid_ff, in_valid_in;
   logic [uqss_pkg::CHAR_W-1:0] in_char_ff;
   logic in_has_ff;
   logic in_qe_ff;
   logic accept;

   logic [7:0] key_limit_ff;
   logic [7:0] value_limit_ff;
   logic [5:0] entry_limit_ff;

   logic [1:0] ph_ff, ph_in;
   logic [7:0] rc_ff, rc_in;
   logic [uqss_pkg::CHAR_W-1:0] pb_ff, pb_in;
   logic [1:0] pc_ff, pc_in;
   logic [ED_W-1:0] ed_ff, ed_in;

   logic at_limit;
   logic [1:0] work_ph;
   logic key_mode;
   logic [uqss_pkg::KIND_W-1:0] byte_kind;
   logic [uqss_pkg::CHAR_W-1:0] c;
   logic [uqss_pkg::CHAR_W-1:0] a;
   logic [uqss_pkg::SLOT_W-1:0] n;
   logic [uqss_pkg::NUM_SLOTS-1:0][uqss_pkg::KIND_W-1:0] kinds;
   logic [uqss_pkg::NUM_SLOTS-1:0][uqss_pkg::CHAR_W-1:0] chars;

   assign load = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !load;
   assign accept = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (load ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_in;
         in_has_ff <= req_has_char;
         in_qe_ff <= req_query_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_limit_ff <= uqss_pkg::KEY_LIMIT_RST;
         value_limit_ff <= uqss_pkg::VALUE_LIMIT_RST;
         entry_limit_ff <= uqss_pkg::ENTRY_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            uqss_pkg::CSR_KEY_LIMIT: key_limit_ff <= csr_wdata;
            uqss_pkg::CSR_VALUE_LIMIT: value_limit_ff <= csr_wdata;
            uqss_pkg::CSR_ENTRY_LIMIT: entry_limit_ff <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   assign at_limit = (ed_ff >= entry_limit_ff) ||
                     (CMP_W'(ed_ff) >= CMP_W'(MAX_ENTRIES));
   assign c = in_char_ff;

   always_comb begin
      work_ph = ph_ff;
      if (in_has_ff && ph_ff == PH_BETWEEN) begin
         work_ph = at_limit ? PH_DONE : PH_KEY;
      end
   end

   assign key_mode = (work_ph == PH_KEY);
   assign byte_kind = key_mode ? uqss_pkg::KIND_KEY : uqss_pkg::KIND_VALUE;

   always_comb begin
      ph_in = ph_ff;
      rc_in = rc_ff;
      pc_in = pc_ff;
      pb_in = pb_ff;
      ed_in = ed_ff;
      n = '0;
      kinds = '0;
      chars = '0;
      a = pb_ff;

      if (in_has_ff) begin
         if (ph_ff == PH_BETWEEN) begin
            ph_in = work_ph;
            if (!at_limit) begin
               rc_in = '0;
               pc_in = '0;
            end
         end
         if (ph_in == PH_KEY || ph_in == PH_VALUE) begin
            if (c == uqss_pkg::CH_AMP) begin
               if (pc_in >= 2'd1) begin
                  kinds[n] = byte_kind;
                  chars[n] = uqss_pkg::fix_byte(uqss_pkg::CH_PERCENT, key_mode);
                  n = n + 3'd1;
               end
               if (pc_in >= 2'd2) begin
                  kinds[n] = byte_kind;
                  chars[n] = uqss_pkg::fix_byte(uqss_pkg::lit(pb_in), key_mode);
                  n = n + 3'd1;
               end
               kinds[n] = uqss_pkg::KIND_ENTRY_END;
               chars[n] = '0;
               n = n + 3'd1;
               ed_in = ed_ff + 6'd1;
               ph_in = PH_BETWEEN;
               rc_in = '0;
               pc_in = '0;
            end else if (c == uqss_pkg::CH_EQUAL && ph_in == PH_KEY) begin
               if (pc_in >= 2'd1) begin
                  kinds[n] = byte_kind;
                  chars[n] = uqss_pkg::fix_byte(uqss_pkg::CH_PERCENT, key_mode);
                  n = n + 3'd1;
               end
               if (pc_in >= 2'd2) begin
                  kinds[n] = byte_kind;
                  chars[n] = uqss_pkg::fix_byte(uqss_pkg::lit(pb_in), key_mode);
                  n = n + 3'd1;
               end
               ph_in = PH_VALUE;
               rc_in = '0;
               pc_in = '0;
            end else if (rc_in < (ph_in == PH_KEY ? key_limit_ff : value_limit_ff)) begin
               rc_in = rc_in + 8'd1;
               unique case (pc_in)
                  2'd0: begin
                     if (c == uqss_pkg::CH_PERCENT) begin
                        pc_in = 2'd1;
                     end else begin
                        kinds[n] = byte_kind;
                        chars[n] = uqss_pkg::fix_byte(uqss_pkg::lit(c), key_mode);
                        n = n + 3'd1;
                     end
                  end
                  2'd1: begin
                     pb_in = c;
                     pc_in = 2'd2;
                  end
                  default: begin
                     a = pb_in;
                     pc_in = 2'd0;
                     if (uqss_pkg::is_hex(a) && uqss_pkg::is_hex(c)) begin
                        kinds[n] = byte_kind;
                        chars[n] = uqss_pkg::fix_byte({uqss_pkg::hex_val(a),
                                                       uqss_pkg::hex_val(c)}, key_mode);
                        n = n + 3'd1;
                     end else begin
                        kinds[n] = byte_kind;
                        chars[n] = uqss_pkg::fix_byte(uqss_pkg::CH_PERCENT, key_mode);
                        n = n + 3'd1;
                        if (a == uqss_pkg::CH_PERCENT) begin
                           pc_in = 2'd1;
                        end else begin
                           kinds[n] = byte_kind;
                           chars[n] = uqss_pkg::fix_byte(uqss_pkg::lit(a), key_mode);
                           n = n + 3'd1;
                        end
                        if (pc_in == 2'd1) begin
                           pb_in = c;
                           pc_in = 2'd2;
                        end else if (c == uqss_pkg::CH_PERCENT) begin
                           pc_in = 2'd1;
                        end else begin
                           kinds[n] = byte_kind;
                           chars[n] = uqss_pkg::fix_byte(uqss_pkg::lit(c), key_mode);
                           n = n + 3'd1;
                        end
                     end
                  end
               endcase
            end
         end
      end

      if (in_qe_ff) begin
         if (ph_in == PH_KEY || ph_in == PH_VALUE) begin
            if (pc_in >= 2'd1) begin
               kinds[n] = byte_kind;
               chars[n] = uqss_pkg::fix_byte(uqss_pkg::CH_PERCENT, key_mode);
               n = n + 3'd1;
            end
            if (pc_in >= 2'd2) begin
               kinds[n] = byte_kind;
               chars[n] = uqss_pkg::fix_byte(uqss_pkg::lit(pb_in), key_mode);
               n = n + 3'd1;
            end
            kinds[n] = uqss_pkg::KIND_ENTRY_END;
            chars[n] = '0;
            n = n + 3'd1;
            ed_in = ed_in + 6'd1;
         end
         kinds[n] = uqss_pkg::KIND_QUERY_END;
         chars[n] = '0;
         n = n + 3'd1;
      end
   end

   assign bundle_count = n;
   assign bundle.kinds = kinds;
   assign bundle.chars = chars;
   assign bundle.index = ed_ff[uqss_pkg::IDX_W-1:0];
   assign bundle.total = ed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_BETWEEN;
         rc_ff <= '0;
         pc_ff <= '0;
         pb_ff <= '0;
         ed_ff <= '0;
      end else if (load) begin
         if (in_qe_ff) begin
            ph_ff <= PH_BETWEEN;
            rc_ff <= '0;
            pc_ff <= '0;
            pb_ff <= '0;
            ed_ff <= '0;
         end else begin
            ph_ff <= ph_in;
            rc_ff <= rc_in;
            pc_ff <= pc_in;
            pb_ff <= pb_in;
            ed_ff <= ed_in;
         end
      end
   end

endmodule

// File: hdl/uqss_out.sv
module uqss_out (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic [uqss_pkg::SLOT_W-1:0] bundle_count,
   input  uqss_pkg::bundle_type bundle,
   output logic out_free,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [uqss_pkg::KIND_W-1:0] rsp_kind,
   output logic [uqss_pkg::CHAR_W-1:0] rsp_char_out,
   output logic [uqss_pkg::IDX_W-1:0] rsp_entry_index,
   output logic [uqss_pkg::TOTAL_W-1:0] rsp_entry_total,
   output logic rsp_last_result
);

   uqss_pkg::bundle_type bundle_ff;
   logic [uqss_pkg::SLOT_W-1:0] cnt_ff, cnt_in;
   logic [uqss_pkg::SLOT_W-1:0] pos_ff, pos_in;
   logic taken;
   logic is_last;
   logic is_qend;

   assign rsp_valid = (cnt_ff != '0);
   assign is_last = (pos_ff == cnt_ff - 3'd1);
   assign taken = rsp_valid && !rsp_stall;
   assign out_free = !rsp_valid || (taken && is_last);

   assign rsp_kind = bundle_ff.kinds[pos_ff];
   assign is_qend = (rsp_kind == uqss_pkg::KIND_QUERY_END);
   assign rsp_char_out = bundle_ff.chars[pos_ff];
   assign rsp_entry_index = is_qend ? '0 : bundle_ff.index;
   assign rsp_entry_total = is_qend ? bundle_ff.total : '0;
   assign rsp_last_result = is_last;

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (load) begin
         cnt_in = bundle_count;
         pos_in = '0;
      end else if (taken) begin
         if (is_last) begin
            cnt_in = '0;
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

endmodule

// File: hdl/url_query_string_splitter_unit.sv
// Splits a query string, fed one byte per item, into decoded key and value bytes, an
// entry-end marker per entry and a query-end marker that carries the entry count. An
// item passes an input register, is parsed and percent-decoded combinationally, and
// its results (up to five) land in a result register that hands them out one per
// cycle while rsp_stall is low. Throughput is one item per cycle while each item
// gives at most one result and rsp_stall is low; an item with more results holds the
// result register until its last result is taken, and an item with no result does
// not hold it. The limit registers may be written only while no item is in flight.
module url_query_string_splitter_unit #(
   parameter int MAX_ENTRIES = uqss_pkg::MAX_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [uqss_pkg::CHAR_W-1:0] req_char_in,
   input  logic req_has_char,
   input  logic req_query_end,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [uqss_pkg::KIND_W-1:0] rsp_kind,
   output logic [uqss_pkg::CHAR_W-1:0] rsp_char_out,
   output logic [uqss_pkg::IDX_W-1:0] rsp_entry_index,
   output logic [uqss_pkg::TOTAL_W-1:0] rsp_entry_total,
   output logic rsp_last_result,
   input  logic csr_write,
   input  logic [uqss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [uqss_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic out_free;
   logic load;
   logic [uqss_pkg::SLOT_W-1:0] bundle_count;
   uqss_pkg::bundle_type bundle;

   uqss_parse #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_in(req_char_in),
      .req_has_char(req_has_char),
      .req_query_end(req_query_end),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .out_free(out_free),
      .load(load),
      .bundle_count(bundle_count),
      .bundle(bundle)
   );

   uqss_out u_out (
      .clock(clock),
      .reset(reset),
      .load(load),
      .bundle_count(bundle_count),
      .bundle(bundle),
      .out_free(out_free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_char_out(rsp_char_out),
      .rsp_entry_index(rsp_entry_index),
      .rsp_entry_total(rsp_entry_total),
      .rsp_last_result(rsp_last_result)
   );

endmodule

// File: test/tb_url_query_string_splitter_unit.sv
`timescale 1ns / 100ps

module tb_url_query_string_splitter_unit;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 40;
   localparam int LONG_PHASE = 5;

   typedef enum logic [1:0] {SEG_IDLE, SEG_KEY, SEG_VALUE, SEG_SKIP} seg_type;

   typedef struct packed {
      logic [uqss_pkg::KIND_W-1:0] kind;
      logic [uqss_pkg::CHAR_W-1:0] ch;
      logic [uqss_pkg::IDX_W-1:0] index;
      logic [uqss_pkg::TOTAL_W-1:0] total;
      logic last;
   } result_type;

   typedef struct packed {
      logic [uqss_pkg::CHAR_W-1:0] ch;
      logic has;
      logic qe;
      logic typed;
      result_type exp;
   } stim_type;

   typedef struct packed {
      logic [7:0] key_lim;
      logic [7:0] val_lim;
      logic [5:0] ent_lim;
   } limits_type;

   localparam result_type NO_RESULT = '0;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [uqss_pkg::CHAR_W-1:0] req_char_in = '0;
   logic req_has_char = 1'b0;
   logic req_query_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [uqss_pkg::KIND_W-1:0] rsp_kind;
   logic [uqss_pkg::CHAR_W-1:0] rsp_char_out;
   logic [uqss_pkg::IDX_W-1:0] rsp_entry_index;
   logic [uqss_pkg::TOTAL_W-1:0] rsp_entry_total;
   logic rsp_last_result;
   logic csr_write = 1'b0;
   logic [uqss_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [uqss_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   url_query_string_splitter_unit dut (.*);

   result_type decoded_q[$];
   result_type step_buf [uqss_pkg::NUM_SLOTS];
   int step_n;

   int key_limit = 31;
   int value_limit = 63;
   int entry_cap = 32;
   seg_type seg = SEG_IDLE;
   int raw_len = 0;
   logic [uqss_pkg::CHAR_W-1:0] esc_hi = '0;
   int esc_len = 0;
   logic [5:0] entries_done = '0;

   bit idle_free = 1'b0;
   int items_sent = 0;
   int queries_sent = 0;
   int results_seen = 0;
   int bad = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   limits_type limit_sets [6] = '{
      '{8'd0, 8'd255, 6'd1},
      '{8'd255, 8'd0, 6'd32},
      '{8'd3, 8'd4, 6'd2},
      '{8'd1, 8'd2, 6'd3},
      '{8'd8, 8'd8, 6'd5},
      '{8'd255, 8'd255, 6'd32}
   };

   stim_type directed_rows [25] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, '{uqss_pkg::KIND_QUERY_END, 8'h00, 5'd0, 6'd0, 1'b1}},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{"A", 1'b1, 1'b0, 1'b1, '{uqss_pkg::KIND_KEY, "a", 5'd0, 6'd0, 1'b1}},
      '{"+", 1'b1, 1'b0, 1'b1, '{uqss_pkg::KIND_KEY, " ", 5'd0, 6'd0, 1'b1}},
      '{"%", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"4", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"1", 1'b1, 1'b0, 1'b1, '{uqss_pkg::KIND_KEY, "a", 5'd0, 6'd0, 1'b1}},
      '{"=", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"=", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b0, 1'b1, '{uqss_pkg::KIND_VALUE, 8'hFF, 5'd0, 6'd0, 1'b1}},
      '{8'h00, 1'b1, 1'b0, 1'b1, '{uqss_pkg::KIND_VALUE, 8'h00, 5'd0, 6'd0, 1'b1}},
      '{"%", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"z", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"Z", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"&", 1'b1, 1'b0, 1'b1, '{uqss_pkg::KIND_ENTRY_END, 8'h00, 5'd0, 6'd0, 1'b1}},
      '{"&", 1'b1, 1'b0, 1'b1, '{uqss_pkg::KIND_ENTRY_END, 8'h00, 5'd1, 6'd0, 1'b1}},
      '{"K", 1'b1, 1'b0, 1'b1, '{uqss_pkg::KIND_KEY, "k", 5'd2, 6'd0, 1'b1}},
      '{"%", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"2", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{"x", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"&", 1'b1, 1'b1, 1'b0, NO_RESULT},
      '{"%", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"4", 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{"z", 1'b1, 1'b1, 1'b0, NO_RESULT}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void emit_result(logic [uqss_pkg::KIND_W-1:0] kind,
                                       logic [uqss_pkg::CHAR_W-1:0] ch,
                                       logic [uqss_pkg::IDX_W-1:0] idx,
                                       logic [uqss_pkg::TOTAL_W-1:0] total);
      if (step_n < uqss_pkg::NUM_SLOTS) begin
         step_buf[step_n] = '{kind, ch, idx, total, 1'b0};
         step_n++;
      end
   endfunction

   function automatic void put_byte(logic [uqss_pkg::CHAR_W-1:0] b);
      logic [uqss_pkg::CHAR_W-1:0] v;
      v = b;
      if (seg == SEG_KEY) begin
         if (v >= "A" && v <= "Z") begin
            v = v + 8'h20;
         end
         emit_result(uqss_pkg::KIND_KEY, v, entries_done[uqss_pkg::IDX_W-1:0], '0);
      end else begin
         emit_result(uqss_pkg::KIND_VALUE, v, entries_done[uqss_pkg::IDX_W-1:0], '0);
      end
   endfunction

   function automatic void put_lit(logic [uqss_pkg::CHAR_W-1:0] c);
      put_byte((c == uqss_pkg::CH_PLUS) ? uqss_pkg::CH_SPACE : c);
   endfunction

   function automatic int hex_of(logic [uqss_pkg::CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // Handles a byte while fewer than two escape bytes are held.
   function automatic void feed_plain(logic [uqss_pkg::CHAR_W-1:0] c);
      if (esc_len == 0) begin
         if (c == uqss_pkg::CH_PERCENT) begin
            esc_len = 1;
         end else begin
            put_lit(c);
         end
      end else begin
         esc_hi = c;
         esc_len = 2;
      end
   endfunction

   function automatic void feed(logic [uqss_pkg::CHAR_W-1:0] c);
      int hi;
      int lo;
      logic [uqss_pkg::CHAR_W-1:0] held;
      if (esc_len < 2) begin
         feed_plain(c);
      end else begin
         held = esc_hi;
         hi = hex_of(held);
         lo = hex_of(c);
         esc_len = 0;
         if (hi >= 0 && lo >= 0) begin
            put_byte({hi[3:0], lo[3:0]});
         end else begin
            put_lit(uqss_pkg::CH_PERCENT);
            feed_plain(held);
            feed_plain(c);
         end
      end
   endfunction

   function automatic void flush_field();
      if (esc_len >= 1) put_lit(uqss_pkg::CH_PERCENT);
      if (esc_len >= 2) put_lit(esc_hi);
      esc_len = 0;
   endfunction

   function automatic void end_entry();
      flush_field();
      emit_result(uqss_pkg::KIND_ENTRY_END, '0, entries_done[uqss_pkg::IDX_W-1:0], '0);
      entries_done = entries_done + 6'd1;
      seg = SEG_IDLE;
      raw_len = 0;
   endfunction

   function automatic void clear_query();
      seg = SEG_IDLE;
      raw_len = 0;
      esc_hi = '0;
      esc_len = 0;
      entries_done = '0;
   endfunction

   function automatic void take_char(logic [uqss_pkg::CHAR_W-1:0] c);
      int cap;
      cap = (entry_cap < uqss_pkg::MAX_ENTRIES_DEF) ? entry_cap : uqss_pkg::MAX_ENTRIES_DEF;
      if (seg == SEG_IDLE) begin
         if (int'(entries_done) >= cap) begin
            seg = SEG_SKIP;
            return;
         end
         seg = SEG_KEY;
         raw_len = 0;
         esc_len = 0;
      end
      if (seg == SEG_KEY) begin
         if (c == uqss_pkg::CH_AMP) begin
            end_entry();
         end else if (c == uqss_pkg::CH_EQUAL) begin
            flush_field();
            seg = SEG_VALUE;
            raw_len = 0;
         end else if (raw_len < key_limit) begin
            raw_len++;
            feed(c);
         end
      end else if (seg == SEG_VALUE) begin
         if (c == uqss_pkg::CH_AMP) begin
            end_entry();
         end else if (raw_len < value_limit) begin
            raw_len++;
            feed(c);
         end
      end
   endfunction

   function automatic void decode_item(logic [uqss_pkg::CHAR_W-1:0] c, logic has, logic qe);
      step_n = 0;
      if (has) take_char(c);
      if (qe) begin
         if (seg == SEG_KEY || seg == SEG_VALUE) end_entry();
         emit_result(uqss_pkg::KIND_QUERY_END, '0, '0, entries_done);
         clear_query();
      end
      if (step_n > 0) step_buf[step_n-1].last = 1'b1;
   endfunction

   function automatic stim_type plain(logic [uqss_pkg::CHAR_W-1:0] c, logic has, logic qe);
      plain = '{c, has, qe, 1'b0, NO_RESULT};
   endfunction

   function automatic logic [uqss_pkg::CHAR_W-1:0] rand_hex();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'("0" + r);
      if (r < 16) return 8'("a" + r - 10);
      return 8'("A" + r - 16);
   endfunction

   function automatic logic [uqss_pkg::CHAR_W-1:0] rand_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return 8'("0" + r - 52);
   endfunction

   task automatic send_item(input stim_type s);
      int gap;
      int k;
      gap = idle_free ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= s.ch;
      req_has_char <= s.has;
      req_query_end <= s.qe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_item(s.ch, s.has, s.qe);
      if (s.typed) begin
         decoded_q.push_back(s.exp);
      end else begin
         for (k = 0; k < step_n; k++) decoded_q.push_back(step_buf[k]);
      end
      items_sent++;
   endtask

   task automatic wait_idle(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [uqss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [uqss_pkg::CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         uqss_pkg::CSR_KEY_LIMIT: key_limit = int'(val);
         uqss_pkg::CSR_VALUE_LIMIT: value_limit = int'(val);
         uqss_pkg::CSR_ENTRY_LIMIT: entry_cap = int'(val[5:0]);
         default: ;
      endcase
   endtask

   task automatic send_token();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         5: send_item(plain(uqss_pkg::CH_PLUS, 1'b1, 1'b0));
         6: begin
            send_item(plain(uqss_pkg::CH_PERCENT, 1'b1, 1'b0));
            send_item(plain(rand_hex(), 1'b1, 1'b0));
            send_item(plain(rand_hex(), 1'b1, 1'b0));
         end
         7: begin
            send_item(plain(uqss_pkg::CH_PERCENT, 1'b1, 1'b0));
            if ($urandom_range(0, 1)) send_item(plain(rand_hex(), 1'b1, 1'b0));
            if ($urandom_range(0, 1)) send_item(plain(rand_alnum(), 1'b1, 1'b0));
         end
         8: send_item(plain(8'($urandom_range(0, 255)), 1'b1, 1'b0));
         9: begin
            if ($urandom_range(0, 1)) begin
               send_item(plain(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            end else begin
               send_item(plain(uqss_pkg::CH_EQUAL, 1'b1, 1'b0));
            end
         end
         default: send_item(plain(rand_alnum(), 1'b1, 1'b0));
      endcase
   endtask

   task automatic send_query(input int n_entries, input bit terse);
      int e;
      int t;
      int n;
      for (e = 0; e < n_entries; e++) begin
         if (e > 0) send_item(plain(uqss_pkg::CH_AMP, 1'b1, 1'b0));
         n = terse ? 1 : $urandom_range(0, 4);
         for (t = 0; t < n; t++) send_token();
         if (!terse && $urandom_range(0, 4) != 0) begin
            send_item(plain(uqss_pkg::CH_EQUAL, 1'b1, 1'b0));
            n = $urandom_range(0, 5);
            for (t = 0; t < n; t++) send_token();
         end
      end
      if ($urandom_range(0, 5) == 0) send_item(plain(uqss_pkg::CH_AMP, 1'b1, 1'b0));
      if ($urandom_range(0, 1)) begin
         send_item(plain(rand_alnum(), 1'b1, 1'b1));
      end else begin
         send_item(plain(8'($urandom_range(0, 255)), 1'b0, 1'b1));
      end
      queries_sent++;
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got = '{rsp_kind, rsp_char_out, rsp_entry_index, rsp_entry_total, rsp_last_result};
      results_seen++;
      if (decoded_q.size() == 0) begin
         if (bad < 10) begin
            $display("Unexpected result: kind %0d char %02h index %0d total %0d last %0d",
                     got.kind, got.ch, got.index, got.total, got.last);
         end
         bad++;
      end else begin
         want = decoded_q.pop_front();
         if (got !== want) begin
            if (bad < 10) begin
               $display("Mismatch on result %0d:", results_seen);
               $display("   expected kind %0d char %02h index %0d total %0d last %0d",
                        want.kind, want.ch, want.index, want.total, want.last);
               $display("   got kind %0d char %02h index %0d total %0d last %0d",
                        got.kind, got.ch, got.index, got.total, got.last);
            end
            bad++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_result();
         stall_left = idle_free ? 0 : $urandom_range(0, 6);
         rsp_stall <= (stall_left != 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", decoded_q.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int p;
      int start;
      limits_type lim;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) send_item(directed_rows[i]);
      for (p = 0; p < 6; p++) begin
         wait_idle(6);
         lim = limit_sets[p];
         write_reg(uqss_pkg::CSR_KEY_LIMIT, lim.key_lim);
         write_reg(uqss_pkg::CSR_VALUE_LIMIT, lim.val_lim);
         write_reg(uqss_pkg::CSR_ENTRY_LIMIT, {2'b00, lim.ent_lim});
         idle_free = (p % 3 == 2);
         start = items_sent;
         if (p == LONG_PHASE) send_query(uqss_pkg::MAX_ENTRIES_DEF + 2, 1'b1);
         while (items_sent - start < PHASE_ITEMS) begin
            send_query($urandom_range(0, 6), 1'b0);
            if ($urandom_range(0, 3) == 0) wait_idle(0);
         end
      end
      idle_free = 1'b0;
      wait_idle(8);
      $display("Sent %0d items: a directed sequence and %0d random queries",
               items_sent, queries_sent);
      $display("under 6 limit settings; checked %0d results, %0d bad, %0d never arrived.",
               results_seen, bad, decoded_q.size());
      if (bad == 0 && decoded_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/uqss_pkg.sv
hdl/uqss_parse.sv
hdl/uqss_out.sv
hdl/url_query_string_splitter_unit.sv
test/tb_url_query_string_splitter_unit.sv
